// File: design/coarse_map_sliding_max_builder_unit_assert.svh
// Assertion shorthands used by the checker file of this block.
`ifndef COARSE_MAP_SLIDING_MAX_BUILDER_UNIT_ASSERT_SVH
`define COARSE_MAP_SLIDING_MAX_BUILDER_UNIT_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define CMSMB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that stays active through reset.
`define CMSMB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: design/cmsmb_pkg.sv
package cmsmb_pkg;

  // Geometry of the window and of one map word.
  localparam int unsigned WINDOW     = 8;
  localparam int unsigned CELL_W     = 6;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CELL_LSB   = 2;
  localparam int unsigned WORD_W     = WINDOW * BYTE_W;
  localparam int unsigned LANES_W    = WINDOW * CELL_W;

  // Map limits.
  localparam int unsigned MAX_WIDTH  = 512;
  localparam int unsigned MAX_HEIGHT = 512;
  localparam int unsigned DIM_W      = 10;
  localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);
  localparam int unsigned CHUNKS_MAX = MAX_WIDTH / WINDOW;
  localparam int unsigned CHUNK_W    = $clog2(CHUNKS_MAX);
  localparam int unsigned CHUNKS_W   = CHUNK_W + 1;
  localparam int unsigned REP_W      = $clog2(WINDOW);

  // Line store: seven older horizontal maxima per column, eight columns per row.
  localparam int unsigned HIST_SLOTS = WINDOW - 1;
  localparam int unsigned HIST_W     = HIST_SLOTS * CELL_W;
  localparam int unsigned MEM_W      = WINDOW * HIST_W;

  // Queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAP_WIDTH  = 1'b0,
    CFG_MAP_HEIGHT = 1'b1
  } cfg_idx_e;

  // One classified word: up to two chunks to finish in the line store.
  typedef struct packed {
    logic                has_a;     // finish chunk k-1 from previous and current word
    logic                has_b;     // finish chunk k from current word and zeros
    logic [CHUNK_W-1:0]  chunk;     // word index k within the row
    logic [LANES_W-1:0]  hmax_a;
    logic [LANES_W-1:0]  hmax_b;
    logic [ROW_W-1:0]    row;
    logic                last_row;
    logic [DIM_W-1:0]    height;
  } entry_t;

  // Horizontal 8-wide maxima for the eight lanes of a 16-cell span.
  function automatic logic [LANES_W-1:0] hmax_lanes(input logic [2*LANES_W-1:0] cells);
    logic [LANES_W-1:0] res;
    logic [CELL_W-1:0]  m;
    logic [CELL_W-1:0]  c;
    res = '0;
    for (int i = 0; i < WINDOW; i++) begin
      m = cells[i*CELL_W +: CELL_W];
      for (int j = 1; j < WINDOW; j++) begin
        c = cells[(i+j)*CELL_W +: CELL_W];
        if (c > m) m = c;
      end
      res[i*CELL_W +: CELL_W] = m;
    end
    return res;
  endfunction

endpackage

// File: design/cmsmb_queue.sv
module cmsmb_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cmsmb_pkg::entry_t entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output cmsmb_pkg::entry_t entry_o
);
  import cmsmb_pkg::*;

  entry_t            store_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = store_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + (QPTR_W+1)'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// File: design/cmsmb_front.sv
module cmsmb_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cmsmb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cmsmb_pkg::DIM_W-1:0]      cfg_data_i,
  input  logic                             push_i,
  input  logic [cmsmb_pkg::WORD_W-1:0]     cell_word_i,
  input  logic                             q_full_i,
  output logic                             q_push_o,
  output cmsmb_pkg::entry_t                q_entry_o
);
  import cmsmb_pkg::*;

  logic [DIM_W-1:0]   map_width_q, map_height_q;
  logic [LANES_W-1:0] prev_q;
  logic [CHUNK_W-1:0] word_q, word_d;
  logic [ROW_W-1:0]   row_q, row_d;

  logic [LANES_W-1:0]  cur_cells;
  logic [DIM_W-1:0]    eff_width, eff_height;
  logic [DIM_W:0]      chunks_sum;
  logic [CHUNKS_W-1:0] chunks;
  logic                last_word, last_row, accept;

  assign accept = push_i && !q_full_i;

  // Pick the 6-bit value out of each byte.
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      cur_cells[i*CELL_W +: CELL_W] = cell_word_i[i*BYTE_W + CELL_LSB +: CELL_W];
    end
  end

  // Saturate the registers and find the row and map boundaries.
  always_comb begin
    eff_width = map_width_q;
    if (map_width_q == '0) begin
      eff_width = DIM_W'(1);
    end else if (map_width_q > DIM_W'(MAX_WIDTH)) begin
      eff_width = DIM_W'(MAX_WIDTH);
    end
    eff_height = map_height_q;
    if (map_height_q < DIM_W'(WINDOW)) begin
      eff_height = DIM_W'(WINDOW);
    end else if (map_height_q > DIM_W'(MAX_HEIGHT)) begin
      eff_height = DIM_W'(MAX_HEIGHT);
    end
    chunks_sum = {1'b0, eff_width} + (DIM_W+1)'(WINDOW - 1);
    chunks     = CHUNKS_W'(chunks_sum >> $clog2(WINDOW));
    last_word  = ({1'b0, word_q} + CHUNKS_W'(1)) >= chunks;
    last_row   = ({1'b0, row_q} + DIM_W'(1)) >= eff_height;
  end

  // Classify the word into the chunks it completes.
  always_comb begin
    q_entry_o.has_a    = (word_q != '0);
    q_entry_o.has_b    = last_word;
    q_entry_o.chunk    = word_q;
    q_entry_o.hmax_a   = hmax_lanes({cur_cells, prev_q});
    q_entry_o.hmax_b   = hmax_lanes({{LANES_W{1'b0}}, cur_cells});
    q_entry_o.row      = row_q;
    q_entry_o.last_row = last_row;
    q_entry_o.height   = eff_height;
  end

  assign q_push_o = accept && ((word_q != '0) || last_word);

  // Word and row position after this transaction.
  always_comb begin
    word_d = word_q + CHUNK_W'(1);
    row_d  = row_q;
    if (last_word) begin
      word_d = '0;
      row_d  = last_row ? '0 : row_q + ROW_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= DIM_W'(WINDOW);
      map_height_q <= DIM_W'(WINDOW);
      prev_q       <= '0;
      word_q       <= '0;
      row_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MAP_WIDTH: begin
            map_width_q <= cfg_data_i;
          end
          CFG_MAP_HEIGHT: begin
            map_height_q <= cfg_data_i;
          end
          default: begin
            map_width_q <= map_width_q;
          end
        endcase
      end
      if (accept) begin
        prev_q <= cur_cells;
        word_q <= word_d;
        row_q  <= row_d;
      end
    end
  end

endmodule

// File: design/cmsmb_back.sv
module cmsmb_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_valid_i,
  input  cmsmb_pkg::entry_t              q_entry_i,
  output logic                           q_pop_o,
  output logic                           empty_o,
  input  logic                           pop_i,
  output logic [cmsmb_pkg::ROW_W-1:0]    coarse_row_o,
  output logic [cmsmb_pkg::CHUNK_W-1:0]  chunk_index_o,
  output logic [cmsmb_pkg::LANES_W-1:0]  lanes_o,
  output logic                           run_end_o
);
  import cmsmb_pkg::*;

  typedef enum logic [2:0] {
    ST_READ = 3'b001,
    ST_CALC = 3'b010,
    ST_EMIT = 3'b100
  } back_state_e;

  back_state_e        state_q, state_d;
  logic               op_sel_q, op_sel_d;
  logic [REP_W-1:0]   rep_q, rep_d;
  logic [LANES_W-1:0] lanes_q, lanes_d;

  logic [MEM_W-1:0]   hist_mem_q [CHUNKS_MAX];
  logic [MEM_W-1:0]   rdata_q;
  logic               mem_re, mem_we;

  logic               out_valid_q;
  logic [ROW_W-1:0]   out_row_q;
  logic [CHUNK_W-1:0] out_chunk_q;
  logic [LANES_W-1:0] out_lanes_q;
  logic               out_end_q;

  logic               cur_b, op_last, emit, out_ready, rep_last, op_done, out_load;
  logic [CHUNK_W-1:0] op_chunk;
  logic [LANES_W-1:0] op_hmax, calc_lanes, out_lanes;
  logic [MEM_W-1:0]   new_hist;
  logic [REP_W-1:0]   out_rep;
  logic [ROW_W-1:0]   out_row;
  logic               out_end;

  // Which of the entry's chunks is being worked on.
  assign cur_b    = op_sel_q || !q_entry_i.has_a;
  assign op_last  = cur_b || !q_entry_i.has_b;
  assign op_chunk = cur_b ? q_entry_i.chunk : q_entry_i.chunk - CHUNK_W'(1);
  assign op_hmax  = cur_b ? q_entry_i.hmax_b : q_entry_i.hmax_a;
  assign emit     = (q_entry_i.row >= ROW_W'(WINDOW - 1));

  // Vertical maximum against the seven older rows and the shifted history.
  always_comb begin : calc
    logic [CELL_W-1:0] h;
    logic [CELL_W-1:0] m;
    logic [CELL_W-1:0] o;
    logic [HIST_W-1:0] old;
    for (int i = 0; i < WINDOW; i++) begin
      h   = op_hmax[i*CELL_W +: CELL_W];
      old = rdata_q[i*HIST_W +: HIST_W];
      m   = h;
      for (int j = 0; j < HIST_SLOTS; j++) begin
        o = old[j*CELL_W +: CELL_W];
        if (o > m) m = o;
      end
      calc_lanes[i*CELL_W +: CELL_W] = m;
      new_hist[i*HIST_W +: HIST_W]   = {old[HIST_W-CELL_W-1:0], h};
    end
  end

  assign out_ready = !out_valid_q || pop_i;

  // Sequencer: read the line store, update it, then hand out the results.
  always_comb begin
    state_d   = state_q;
    op_sel_d  = op_sel_q;
    rep_d     = rep_q;
    lanes_d   = lanes_q;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    out_load  = 1'b0;
    out_rep   = rep_q;
    out_lanes = lanes_q;
    op_done   = 1'b0;
    q_pop_o   = 1'b0;
    case (state_q)
      ST_READ: begin
        if (q_valid_i) begin
          mem_re  = 1'b1;
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        mem_we  = 1'b1;
        lanes_d = calc_lanes;
        if (emit) begin
          if (out_ready) begin
            out_load  = 1'b1;
            out_rep   = '0;
            out_lanes = calc_lanes;
            if (q_entry_i.last_row) begin
              rep_d   = REP_W'(1);
              state_d = ST_EMIT;
            end else begin
              op_done = 1'b1;
            end
          end else begin
            rep_d   = '0;
            state_d = ST_EMIT;
          end
        end else begin
          op_done = 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_ready) begin
          out_load = 1'b1;
          if (rep_last) begin
            op_done = 1'b1;
          end else begin
            rep_d = rep_q + REP_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_READ;
      end
    endcase
    if (op_done) begin
      state_d = ST_READ;
      rep_d   = '0;
      if (op_last) begin
        q_pop_o  = 1'b1;
        op_sel_d = 1'b0;
      end else begin
        op_sel_d = 1'b1;
      end
    end
  end

  // The first result is the window row; copies cover the final seven rows.
  assign rep_last = q_entry_i.last_row ? (rep_q == REP_W'(WINDOW - 1)) : (rep_q == '0);
  assign out_row  = (out_rep == '0) ? q_entry_i.row - ROW_W'(WINDOW - 1)
                                    : ROW_W'(q_entry_i.height - DIM_W'(out_rep));
  assign out_end  = op_last && (q_entry_i.last_row ? (out_rep == REP_W'(WINDOW - 1))
                                                   : (out_rep == '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_READ;
      op_sel_q    <= 1'b0;
      rep_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      op_sel_q <= op_sel_d;
      rep_q    <= rep_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    lanes_q <= lanes_d;
    if (out_load) begin
      out_row_q   <= out_row;
      out_chunk_q <= op_chunk;
      out_lanes_q <= out_lanes;
      out_end_q   <= out_end;
    end
  end

  // Line store: one row of eight columns per chunk, registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem_q[op_chunk] <= new_hist;
    end
    if (mem_re) begin
      rdata_q <= hist_mem_q[op_chunk];
    end
  end

  assign empty_o       = !out_valid_q;
  assign coarse_row_o  = out_row_q;
  assign chunk_index_o = out_chunk_q;
  assign lanes_o       = out_lanes_q;
  assign run_end_o     = out_end_q;

endmodule

// File: design/coarse_map_sliding_max_builder_unit.sv
// A result passes through the queue, the line store read register and the output register.
// Each completed chunk takes a line store read, then an update and write back: the first
// word of a longer row completes none, its last word two, any other word one; on the last
// map row each chunk also gives seven copies. A four-entry queue decouples the input.
// Reset: counters and previous word clear, registers return to width 8 and height 8;
// the line store is not cleared and is valid once written.
module coarse_map_sliding_max_builder_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cmsmb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cmsmb_pkg::DIM_W-1:0]      cfg_data_i,
  input  logic                             push,
  output logic                             full,
  input  logic [cmsmb_pkg::WORD_W-1:0]     cell_word_i,
  output logic                             empty,
  input  logic                             pop,
  output logic [cmsmb_pkg::ROW_W-1:0]      coarse_row_o,
  output logic [cmsmb_pkg::CHUNK_W-1:0]    chunk_index_o,
  output logic [cmsmb_pkg::CELL_W-1:0]     max_lane0_o,
  output logic [cmsmb_pkg::CELL_W-1:0]     max_lane1_o,
  output logic [cmsmb_pkg::CELL_W-1:0]     max_lane2_o,
  output logic [cmsmb_pkg::CELL_W-1:0]     max_lane3_o,
  output logic [cmsmb_pkg::CELL_W-1:0]     max_lane4_o,
  output logic [cmsmb_pkg::CELL_W-1:0]     max_lane5_o,
  output logic [cmsmb_pkg::CELL_W-1:0]     max_lane6_o,
  output logic [cmsmb_pkg::CELL_W-1:0]     max_lane7_o,
  output logic                             run_end_o
);
  import cmsmb_pkg::*;

  logic               q_push, q_full, q_pop, q_valid;
  entry_t             q_in, q_head;
  logic [LANES_W-1:0] lanes;

  // Front: registers, word position and chunk classification.
  cmsmb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_i      (push),
    .cell_word_i (cell_word_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (q_in)
  );

  // Queue of classified words.
  cmsmb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_head)
  );

  // Back: line store update and result delivery.
  cmsmb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_entry_i     (q_head),
    .q_pop_o       (q_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .coarse_row_o  (coarse_row_o),
    .chunk_index_o (chunk_index_o),
    .lanes_o       (lanes),
    .run_end_o     (run_end_o)
  );

  assign full        = q_full;
  assign max_lane0_o = lanes[0*CELL_W +: CELL_W];
  assign max_lane1_o = lanes[1*CELL_W +: CELL_W];
  assign max_lane2_o = lanes[2*CELL_W +: CELL_W];
  assign max_lane3_o = lanes[3*CELL_W +: CELL_W];
  assign max_lane4_o = lanes[4*CELL_W +: CELL_W];
  assign max_lane5_o = lanes[5*CELL_W +: CELL_W];
  assign max_lane6_o = lanes[6*CELL_W +: CELL_W];
  assign max_lane7_o = lanes[7*CELL_W +: CELL_W];

endmodule

// File: design/cmsmb_checker.sv
`include "coarse_map_sliding_max_builder_unit_assert.svh"

module cmsmb_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             push_i,
  input logic                             full_i,
  input logic                             empty_i,
  input logic                             pop_i,
  input logic [cmsmb_pkg::ROW_W-1:0]      coarse_row_i,
  input logic [cmsmb_pkg::CHUNK_W-1:0]    chunk_index_i,
  input logic [cmsmb_pkg::LANES_W-1:0]    lanes_i,
  input logic                             run_end_i
);
  import cmsmb_pkg::*;

  // A waiting result holds until it is taken.
  `CMSMB_ASSERT(a_result_hold, (!empty_i && !pop_i) |=> (!empty_i && $stable(coarse_row_i) && $stable(chunk_index_i) && $stable(lanes_i) && $stable(run_end_i)), "result changed while stalled")

  // The queue fills only through an input transaction.
  `CMSMB_ASSERT(a_full_by_push, $rose(full_i) |-> $past(push_i), "full rose without an input transaction")

  // Leaving reset, nothing is pending and input is open.
  `CMSMB_ASSERT_ALWAYS(a_reset_idle, $rose(rst_ni) |-> (empty_i && !full_i), "block not idle after reset")

endmodule

bind coarse_map_sliding_max_builder_unit cmsmb_checker u_cmsmb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .push_i        (push),
  .full_i        (full),
  .empty_i       (empty),
  .pop_i         (pop),
  .coarse_row_i  (coarse_row_o),
  .chunk_index_i (chunk_index_o),
  .lanes_i       ({max_lane7_o, max_lane6_o, max_lane5_o, max_lane4_o,
                   max_lane3_o, max_lane2_o, max_lane1_o, max_lane0_o}),
  .run_end_i     (run_end_o)
);

// File: tb/sv/tb_coarse_map_sliding_max_builder_unit.sv
`timescale 1ns / 1ps

module tb_coarse_map_sliding_max_builder_unit;
  import cmsmb_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned CYCLE_LIMIT   = 500_000;
  localparam int unsigned RANDOM_WORDS  = 200;
  localparam int unsigned MAX_REPORTS   = 40;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  // One coarse chunk as it leaves the block.
  typedef struct packed {
    logic [ROW_W-1:0]               row;
    logic [CHUNK_W-1:0]             chunk;
    logic [WINDOW-1:0][CELL_W-1:0]  lanes;
    logic                           run_end;
  } coarse_chunk_t;

  // Predicts coarse chunks from accepted map words and checks the block's results.
  class coarse_map_scoreboard;
    logic [CELL_W-1:0] prev_cells [WINDOW];
    logic [HIST_W-1:0] line_store [MAX_WIDTH];
    int unsigned       row_cnt;
    int unsigned       word_cnt;
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    coarse_chunk_t     expected_chunks [$];
    int unsigned       errors;

    function void clear();
      foreach (prev_cells[i]) prev_cells[i] = '0;
      foreach (line_store[i]) line_store[i] = '0;
      row_cnt = 0;
      word_cnt = 0;
      width_reg = 8;
      height_reg = 8;
      expected_chunks.delete();
      errors = 0;
    endfunction

    function void set_reg(input cfg_idx_e idx, input logic [DIM_W-1:0] value);
      case (idx)
        CFG_MAP_WIDTH:  width_reg = value;
        CFG_MAP_HEIGHT: height_reg = value;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_chunks.size();
    endfunction

    function bit at_map_start();
      return (row_cnt == 0) && (word_cnt == 0);
    endfunction

    // Out-of-range sizes are clamped to what the line store supports.
    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      if (height_reg < WINDOW) return WINDOW;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return height_reg;
    endfunction

    // Folds one 16-cell span into the line store and queues the chunks it completes.
    function int fold_chunk(input logic [CELL_W-1:0] span [2*WINDOW],
                            input int unsigned chunk, input bit last_row,
                            input int unsigned height);
      coarse_chunk_t     item;
      logic [CELL_W-1:0] hmax;
      logic [CELL_W-1:0] best;
      logic [HIST_W-1:0] older;
      int unsigned       col;
      item.chunk = CHUNK_W'(chunk);
      item.run_end = 1'b0;
      for (int i = 0; i < WINDOW; i++) begin
        hmax = '0;
        for (int j = 0; j < WINDOW; j++)
          if (span[i+j] > hmax) hmax = span[i+j];
        col = chunk * WINDOW + i;
        older = line_store[col];
        best = hmax;
        for (int j = 0; j < WINDOW - 1; j++)
          if (older[j*CELL_W +: CELL_W] > best) best = older[j*CELL_W +: CELL_W];
        line_store[col] = {older[HIST_W-CELL_W-1:0], hmax};
        item.lanes[i] = best;
      end
      // Nothing leaves the block until the window holds eight rows.
      if (row_cnt < WINDOW - 1) return 0;
      item.row = ROW_W'(row_cnt - (WINDOW - 1));
      expected_chunks.push_back(item);
      if (!last_row) return 1;
      // The last row repeats the chunk for the bottom seven coarse rows.
      for (int k = 1; k < WINDOW; k++) begin
        item.row = ROW_W'(height - k);
        expected_chunks.push_back(item);
      end
      return WINDOW;
    endfunction

    function void absorb_word(input logic [WORD_W-1:0] word);
      logic [CELL_W-1:0] cur [WINDOW];
      logic [CELL_W-1:0] span [2*WINDOW];
      coarse_chunk_t     tail;
      int unsigned       chunks;
      int unsigned       height;
      bit                last_word;
      bit                last_row;
      int                produced;
      chunks = (eff_width() + 7) >> 3;
      height = eff_height();
      last_word = (word_cnt + 1 >= chunks);
      last_row = (row_cnt + 1 >= height);
      produced = 0;
      for (int i = 0; i < WINDOW; i++) cur[i] = word[i*BYTE_W + CELL_LSB +: CELL_W];

      // A later word completes the chunk that started in the previous word.
      if (word_cnt > 0) begin
        for (int i = 0; i < WINDOW; i++) begin
          span[i] = prev_cells[i];
          span[WINDOW+i] = cur[i];
        end
        produced += fold_chunk(span, word_cnt - 1, last_row, height);
      end
      // The last word of a row also completes its own chunk against zeros.
      if (last_word) begin
        for (int i = 0; i < WINDOW; i++) begin
          span[i] = cur[i];
          span[WINDOW+i] = '0;
        end
        produced += fold_chunk(span, word_cnt, last_row, height);
      end
      prev_cells = cur;

      if (last_word) begin
        word_cnt = 0;
        row_cnt = last_row ? 0 : row_cnt + 1;
      end else begin
        word_cnt = word_cnt + 1;
      end

      if (produced > 0) begin
        tail = expected_chunks.pop_back();
        tail.run_end = 1'b1;
        expected_chunks.push_back(tail);
      end
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task check_result(input coarse_chunk_t got);
      coarse_chunk_t want;
      string         diffs;
      if (expected_chunks.size() == 0) begin
        report($sformatf("unexpected chunk row %0d chunk %0d", got.row, got.chunk));
        return;
      end
      want = expected_chunks.pop_front();
      diffs = "";
      if (got.row !== want.row)
        diffs = {diffs, $sformatf(" row %0d/%0d", got.row, want.row)};
      if (got.chunk !== want.chunk)
        diffs = {diffs, $sformatf(" chunk %0d/%0d", got.chunk, want.chunk)};
      for (int i = 0; i < WINDOW; i++)
        if (got.lanes[i] !== want.lanes[i])
          diffs = {diffs, $sformatf(" lane%0d %0d/%0d", i, got.lanes[i], want.lanes[i])};
      if (got.run_end !== want.run_end)
        diffs = {diffs, $sformatf(" run_end %0b/%0b", got.run_end, want.run_end)};
      if (diffs != "")
        report($sformatf("row %0d chunk %0d (got/expected):%s", want.row, want.chunk, diffs));
    endtask
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [DIM_W-1:0]       cfg_data_i;
  logic                   push;
  logic                   full;
  logic [WORD_W-1:0]      cell_word_i;
  logic                   empty;
  logic                   pop;
  logic [ROW_W-1:0]       coarse_row_o;
  logic [CHUNK_W-1:0]     chunk_index_o;
  logic [CELL_W-1:0]      max_lane0_o;
  logic [CELL_W-1:0]      max_lane1_o;
  logic [CELL_W-1:0]      max_lane2_o;
  logic [CELL_W-1:0]      max_lane3_o;
  logic [CELL_W-1:0]      max_lane4_o;
  logic [CELL_W-1:0]      max_lane5_o;
  logic [CELL_W-1:0]      max_lane6_o;
  logic [CELL_W-1:0]      max_lane7_o;
  logic                   run_end_o;

  coarse_map_scoreboard   board;
  int unsigned            send_idle_pct = 0;
  int unsigned            pop_stall_pct = 0;
  int unsigned            words_sent = 0;
  int unsigned            cycle_count = 0;

  // Probe words for the first map: empty cells, ignored low bits, single cells per lane.
  logic [WORD_W-1:0] probe_words [WINDOW] = '{
    64'h0000_0000_0000_0000,
    64'h0303_0303_0303_0303,
    64'h0000_0000_0000_00FC,
    64'h0400_0000_0000_0000,
    64'h0008_0000_0000_0000,
    64'h0000_0000_8000_0000,
    64'h0000_7C00_0000_0000,
    64'h1014_181C_2024_282C
  };

  coarse_map_sliding_max_builder_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .push          (push),
    .full          (full),
    .cell_word_i   (cell_word_i),
    .empty         (empty),
    .pop           (pop),
    .coarse_row_o  (coarse_row_o),
    .chunk_index_o (chunk_index_o),
    .max_lane0_o   (max_lane0_o),
    .max_lane1_o   (max_lane1_o),
    .max_lane2_o   (max_lane2_o),
    .max_lane3_o   (max_lane3_o),
    .max_lane4_o   (max_lane4_o),
    .max_lane5_o   (max_lane5_o),
    .max_lane6_o   (max_lane6_o),
    .max_lane7_o   (max_lane7_o),
    .run_end_o     (run_end_o)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      board.report($sformatf("timeout with %0d chunks outstanding", board.pending()));
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: pop decided at the falling edge, stalling at the current rate.
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      pop <= ($urandom_range(0, 99) >= pop_stall_pct);
    end
  end

  // Every result transaction is checked against the oldest prediction.
  always @(posedge clk_i) begin : result_monitor
    coarse_chunk_t seen;
    if (rst_ni && pop && !empty) begin
      seen.row = coarse_row_o;
      seen.chunk = chunk_index_o;
      seen.lanes = {max_lane7_o, max_lane6_o, max_lane5_o, max_lane4_o,
                    max_lane3_o, max_lane2_o, max_lane1_o, max_lane0_o};
      seen.run_end = run_end_o;
      board.check_result(seen);
    end
  end

  // Sparse cells keep the window maxima spread over the whole value range.
  function automatic logic [WORD_W-1:0] random_word(input int unsigned density);
    logic [WORD_W-1:0] w;
    for (int i = 0; i < WINDOW; i++) begin
      if ($urandom_range(0, 99) < density) w[i*BYTE_W +: BYTE_W] = BYTE_W'($urandom_range(0, 255));
      else w[i*BYTE_W +: BYTE_W] = BYTE_W'($urandom_range(0, 3));
    end
    return w;
  endfunction

  task automatic set_idle(input idle_mode_e mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  pop_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 48; pop_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  pop_stall_pct = 48; end
      default:       begin send_idle_pct = 28; pop_stall_pct = 28; end
    endcase
  endtask

  // Entered and left at a falling edge; push stays high between back-to-back words.
  task automatic send_word(input logic [WORD_W-1:0] word);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    cell_word_i <= word;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    board.absorb_word(word);
    words_sent++;
    @(negedge clk_i);
  endtask

  // Sends random words until the predictor is back at the start of a map.
  task automatic run_map(input int unsigned density);
    do begin
      send_word(random_word(density));
      // Now and then hold the stream until every expected chunk has come out.
      if ($urandom_range(0, 149) == 0) begin
        push <= 1'b0;
        @(negedge clk_i);
        while (board.pending() != 0) @(negedge clk_i);
      end
    end while (!board.at_map_start());
  endtask

  // Waits for all results and lets words that cause none work through the block.
  task automatic quiesce();
    push <= 1'b0;
    @(negedge clk_i);
    while (board.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic configure(input logic [DIM_W-1:0] width, input logic [DIM_W-1:0] height);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_MAP_WIDTH;
    cfg_data_i <= width;
    @(posedge clk_i);
    board.set_reg(CFG_MAP_WIDTH, width);
    @(negedge clk_i);
    cfg_index_i <= CFG_MAP_HEIGHT;
    cfg_data_i <= height;
    @(posedge clk_i);
    board.set_reg(CFG_MAP_HEIGHT, height);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int unsigned random_start;
    int unsigned phase;
    board = new;
    board.clear();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_MAP_WIDTH;
    cfg_data_i = '0;
    push = 1'b0;
    cell_word_i = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset sizes: one word per row, all chunks appear on the eighth word.
    for (int n = 0; n < WINDOW; n++) send_word(probe_words[n]);
    quiesce();

    // Width 9 counts the cells past it in the last word; height 0 clamps to eight.
    configure(9, 0);
    for (int n = 0; n < 2 * WINDOW; n++) send_word((n == 1) ? '1 : random_word(30));
    quiesce();

    // Random maps of mostly small sizes, rotating through the idle patterns.
    random_start = words_sent;
    phase = 0;
    while (words_sent - random_start < RANDOM_WORDS) begin
      set_idle(idle_mode_e'(phase % 4));
      configure(DIM_W'(($urandom_range(0, 7) == 0) ? $urandom_range(49, 128)
                                                   : $urandom_range(1, 48)),
                DIM_W'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 7)
                                                   : $urandom_range(8, 12)));
      run_map($urandom_range(2, 40));
      quiesce();
      phase++;
    end

    // Width 0 and height 1023 clamp; the height then drops below the current row.
    set_idle(IDLE_BOTH);
    configure(0, 1023);
    for (int n = 0; n < 40; n++) send_word(random_word(12));
    quiesce();
    configure(0, 30);
    run_map(12);
    quiesce();

    // Width shrinks in the middle of a row, so the current word closes the row.
    set_idle(IDLE_SENDER);
    configure(40, 12);
    for (int n = 0; n < 9 * 5 + 3; n++) send_word(random_word(20));
    quiesce();
    configure(16, 12);
    run_map(20);
    quiesce();

    // Width 1023 clamps to the full line store: the first row runs up to its last
    // chunk, then a narrow width makes the next word close the row there.
    set_idle(IDLE_RECEIVER);
    configure(1023, 8);
    for (int n = 0; n < CHUNKS_MAX - 1; n++) send_word(random_word(30));
    quiesce();
    configure(8, 8);
    run_map(30);
    quiesce();

    if (board.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/cmsmb_pkg.sv
design/cmsmb_queue.sv
design/cmsmb_front.sv
design/cmsmb_back.sv
design/coarse_map_sliding_max_builder_unit.sv
design/cmsmb_checker.sv
tb/sv/tb_coarse_map_sliding_max_builder_unit.sv
